>>> rtl/core/assert_macros.svh
// Assertion macros shared by the replacement-order RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed")
// Check that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed")
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/tlru_pkg.sv
// Types and codes shared by the true-LRU replacement block.
package tlru_pkg;

	localparam int FRAME_W = 4;

	localparam logic [1:0] MODE_TOUCH  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_VICTIM = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FRAME_W-1:0] frame;
	} request_t;

	typedef struct packed {
		logic [FRAME_W-1:0] victim_frame;
		logic               list_empty;
	} result_t;

endpackage

>>> rtl/core/true_lru_replacement.sv
// True-LRU replacement order: request register, recency list and result register.
//
// Keeps the cache frames in recency order and answers one transaction per clock:
// start is taken whenever it is high (busy is never raised), and a victim request
// reports the least recently used frame through the request register and the result register,
// with done high for exactly one cycle. Touch and insert transactions give no result.
// Every transaction edits the link arrays held in flip-flops in one pass, so the next
// transaction sees its effect with no bubble. The receiver cannot stall the result.
`include "assert_macros.svh"
module true_lru_replacement
	import tlru_pkg::*;
#(
	parameter int FRAMES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	logic     valid_s1;
	request_t req_s1;
	logic     done_s2;
	result_t  result_s2;
	result_t  victim;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start;
			done_s2  <= valid_s1 && (req_s1.mode == MODE_VICTIM);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= request;
		end
		result_s2 <= victim;
	end

	tlru_list #(
		.FRAMES(FRAMES)
	) u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.request(req_s1),
		.victim (victim)
	);

	assign done   = done_s2;
	assign result = result_s2;

	`ASSERT_NEXT(a_done_only_for_victim, clk, arst_n,
		!(valid_s1 && (req_s1.mode == MODE_VICTIM)), !done);
	`ASSERT_HOLDS(a_empty_reports_zero, clk, arst_n,
		!(done && result.list_empty) || (result.victim_frame == '0));

endmodule

>>> rtl/core/tlru_list.sv
// Recency list: link arrays, head and tail pointers and their single-pass update.
`include "assert_macros.svh"
module tlru_list
	import tlru_pkg::*;
#(
	parameter int FRAMES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid,
	input  request_t request,
	output result_t  victim
);

	localparam int LINK_W = $clog2(FRAMES + 1);
	localparam int IDX_W  = $clog2(FRAMES);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(FRAMES);

	logic [LINK_W-1:0] prev_q [FRAMES];
	logic [LINK_W-1:0] next_q [FRAMES];
	logic [LINK_W-1:0] prev_d [FRAMES];
	logic [LINK_W-1:0] next_d [FRAMES];
	logic [LINK_W-1:0] head_q, tail_q, head_d, tail_d;

	logic              f_ok, tail_ok;
	logic              is_touch, is_insert, do_vict, do_detach, do_link;
	logic [LINK_W-1:0] f_link, tgt, p, n, head1, tail1;
	logic              wr_next_p, wr_prev_n, wr_prev_h;

	function automatic logic is_frame(input logic [LINK_W-1:0] x);
		return x < NULL_LINK;
	endfunction

	always_comb begin
		f_ok      = (32'(request.frame) < 32'(FRAMES));
		f_link    = LINK_W'(request.frame);
		tail_ok   = is_frame(tail_q);
		is_touch  = valid && (request.mode == MODE_TOUCH) && f_ok;
		is_insert = valid && (request.mode == MODE_INSERT) && f_ok;
		do_vict   = valid && (request.mode == MODE_VICTIM) && tail_ok;
		do_detach = is_touch || do_vict;
		do_link   = is_touch || is_insert;
		tgt       = do_vict ? tail_q : f_link;
		p         = prev_q[tgt[IDX_W-1:0]];
		n         = next_q[tgt[IDX_W-1:0]];

		// unlink the target first, then splice the frame in at the head
		wr_next_p = do_detach && (p != NULL_LINK) && is_frame(p);
		wr_prev_n = do_detach && (n != NULL_LINK) && is_frame(n);
		head1 = head_q;
		if (do_detach && (p == NULL_LINK) && (head_q == tgt)) begin
			head1 = n;
		end
		tail1 = tail_q;
		if (do_detach && (n == NULL_LINK) && (tail_q == tgt)) begin
			tail1 = p;
		end
		wr_prev_h = do_link && (head1 != NULL_LINK) && is_frame(head1);
		head_d = do_link ? f_link : head1;
		tail_d = (do_link && (tail1 == NULL_LINK)) ? f_link : tail1;

		// later edits win, in the order the list operations apply them
		for (int i = 0; i < FRAMES; i++) begin
			prev_d[i] = prev_q[i];
			if (wr_prev_n && (n == LINK_W'(i))) begin
				prev_d[i] = p;
			end
			if (do_link && (f_link == LINK_W'(i))) begin
				prev_d[i] = NULL_LINK;
			end
			if (wr_prev_h && (head1 == LINK_W'(i))) begin
				prev_d[i] = f_link;
			end
			next_d[i] = next_q[i];
			if (wr_next_p && (p == LINK_W'(i))) begin
				next_d[i] = n;
			end
			if (do_link && (f_link == LINK_W'(i))) begin
				next_d[i] = head1;
			end
		end

		victim.list_empty   = !tail_ok;
		victim.victim_frame = tail_ok ? FRAME_W'(tail_q) : '0;
	end

	always_ff @(posedge clk) begin
		prev_q <= prev_d;
		next_q <= next_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NULL_LINK;
			tail_q <= NULL_LINK;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	`ASSERT_NEXT(a_insert_sets_head, clk, arst_n, is_insert, head_q == $past(f_link));
	`ASSERT_NEXT(a_empty_victim_keeps_list, clk, arst_n,
		valid && (request.mode == MODE_VICTIM) && !tail_ok,
		$stable(head_q) && $stable(tail_q));

endmodule

>>> tb/true_lru_replacement_tb.sv
// Self-checking testbench for the true-LRU replacement order block.
module true_lru_replacement_tb;
	import tlru_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         NUM_FRAMES  = 16;
	localparam logic [4:0] NO_FRAME    = 5'd16;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         STALL_LIMIT = 2000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t request = '0;
	logic     done;
	result_t  result;

	true_lru_replacement #(.FRAMES(NUM_FRAMES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	// Recency list as the block should hold it
	logic [4:0]  lru_prev [NUM_FRAMES];
	logic [4:0]  lru_next [NUM_FRAMES];
	logic [4:0]  lru_head = NO_FRAME;
	logic [4:0]  lru_tail = NO_FRAME;
	logic [15:0] frame_written = '0;
	result_t     victim_q [$];
	int          error_count = 0;
	int          gap_ceiling = 0;
	int          idle_cycles = 0;

	initial begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			lru_prev[i] = '0;
			lru_next[i] = '0;
		end
	end

	function automatic void unlink_frame(input logic [4:0] f);
		logic [4:0] p;
		logic [4:0] n;
		p = lru_prev[f[3:0]];
		n = lru_next[f[3:0]];
		if (p != NO_FRAME) begin
			if (p < NO_FRAME)
				lru_next[p[3:0]] = n;
		end else if (lru_head == f) begin
			lru_head = n;
		end
		if (n != NO_FRAME) begin
			if (n < NO_FRAME)
				lru_prev[n[3:0]] = p;
		end else if (lru_tail == f) begin
			lru_tail = p;
		end
	endfunction

	function automatic void link_most_recent(input logic [4:0] f);
		lru_prev[f[3:0]] = NO_FRAME;
		lru_next[f[3:0]] = lru_head;
		if (lru_head < NO_FRAME)
			lru_prev[lru_head[3:0]] = f;
		lru_head = f;
		if (lru_tail == NO_FRAME)
			lru_tail = f;
		frame_written[f[3:0]] = 1'b1;
	endfunction

	function automatic void update_recency(input request_t req);
		logic [4:0] v;
		case (req.mode)
			MODE_TOUCH, MODE_INSERT: begin
				if (req.mode == MODE_TOUCH)
					unlink_frame({1'b0, req.frame});
				link_most_recent({1'b0, req.frame});
			end
			MODE_VICTIM: begin
				v = lru_tail;
				if (v >= NO_FRAME) begin
					victim_q.push_back(result_t'{victim_frame: '0, list_empty: 1'b1});
				end else begin
					unlink_frame(v);
					victim_q.push_back(result_t'{victim_frame: v[3:0], list_empty: 1'b0});
				end
			end
			default: ;
		endcase
	endfunction

	// Frames reachable from the head, walk bounded in case the links loop
	function automatic logic [15:0] linked_frames();
		logic [15:0] set;
		logic [4:0]  cur;
		set = '0;
		cur = lru_head;
		for (int i = 0; i < NUM_FRAMES && cur < NO_FRAME; i++) begin
			set[cur[3:0]] = 1'b1;
			cur = lru_next[cur[3:0]];
		end
		return set;
	endfunction

	function automatic logic [3:0] pick_frame(input logic [15:0] set);
		int k;
		k = $urandom_range(0, $countones(set) - 1);
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (set[i]) begin
				if (k == 0)
					return 4'(i);
				k--;
			end
		end
		return '0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Call at a rising edge; returns at the edge that accepts the transaction
	task automatic send_request(input logic [1:0] mode, input logic [3:0] frame);
		int      gap;
		request_t req;
		req.mode  = mode;
		req.frame = frame;
		gap = $urandom_range(0, gap_ceiling);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		do @(negedge clk); while (busy);
		@(posedge clk);
		update_recency(req);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (victim_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Results are stable mid-cycle; sample them away from the rising edge
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (victim_q.size() == 0) begin
				report_mismatch($sformatf("result with none expected: frame %0d empty %0b",
					result.victim_frame, result.list_empty));
			end else begin
				result_t want;
				want = victim_q.pop_front();
				if (result.victim_frame !== want.victim_frame)
					report_mismatch($sformatf("victim_frame %0d, expected %0d",
						result.victim_frame, want.victim_frame));
				if (result.list_empty !== want.list_empty)
					report_mismatch($sformatf("list_empty %0b, expected %0b",
						result.list_empty, want.list_empty));
			end
		end
	end

	always @(negedge clk) begin
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("true_lru_replacement regression: fail");
			$finish;
		end
	end

	task automatic test_directed_cases();
		gap_ceiling = 2;
		send_request(MODE_VICTIM, 4'hF);   // empty list
		send_request(MODE_INSERT, 4'h0);
		send_request(MODE_INSERT, 4'hF);
		send_request(MODE_TOUCH, 4'h0);    // tail to head
		send_request(MODE_VICTIM, 4'h0);
		send_request(MODE_VICTIM, 4'hA);
		send_request(MODE_VICTIM, 4'h5);   // empty again
		send_request(MODE_INSERT, 4'h5);
		send_request(MODE_INSERT, 4'h3);
		send_request(MODE_INSERT, 4'h9);
		send_request(MODE_TOUCH, 4'h3);    // middle of list
		send_request(MODE_TOUCH, 4'h3);    // already at head
		send_request(MODE_TOUCH, 4'h5);    // tail
		send_request(MODE_UNUSED, 4'h7);
		send_request(MODE_UNUSED, 4'h8);
		send_request(MODE_VICTIM, 4'h0);
		send_request(MODE_VICTIM, 4'hF);
		send_request(MODE_VICTIM, 4'h0);
		send_request(MODE_VICTIM, 4'h0);
		wait_for_results();
	endtask

	task automatic test_full_list();
		gap_ceiling = 0;
		repeat (NUM_FRAMES)
			send_request(MODE_INSERT, pick_frame(~linked_frames()));
		repeat (8)
			send_request(MODE_TOUCH, pick_frame(linked_frames()));
		repeat (NUM_FRAMES + 1)
			send_request(MODE_VICTIM, 4'($urandom));
		wait_for_results();
	endtask

	task automatic send_legal_request();
		logic [15:0] set;
		int          roll;
		set  = linked_frames();
		roll = $urandom_range(0, 99);
		if (roll < 4)
			send_request(MODE_UNUSED, 4'($urandom));
		else if (roll < 44 && set != '0)
			send_request(MODE_TOUCH, pick_frame(set));
		else if (roll < 74 && set != '1)
			send_request(MODE_INSERT, pick_frame(~set));
		else
			send_request(MODE_VICTIM, 4'($urandom));
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				gap_ceiling = $urandom_range(0, 1) ? 18 : 0;
			if (i % 200 == 199)
				wait_for_results();
			send_legal_request();
		end
		wait_for_results();
	endtask

	// Touch detached frames and re-insert linked ones; runs last as it may tangle the list
	task automatic test_broken_preconditions(input int count);
		logic [15:0] set;
		logic [15:0] stale;
		int          roll;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				gap_ceiling = $urandom_range(0, 1) ? 18 : 0;
			set   = linked_frames();
			stale = frame_written & ~set;
			roll  = $urandom_range(0, 99);
			if (roll < 20 && stale != '0)
				send_request(MODE_TOUCH, pick_frame(stale));
			else if (roll < 40 && set != '0)
				send_request(MODE_INSERT, pick_frame(set));
			else
				send_legal_request();
		end
		wait_for_results();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_list();
		test_random_traffic(1350);
		test_broken_preconditions(250);
		repeat (4) @(posedge clk);
		if (error_count == 0 && victim_q.size() == 0)
			$display("true_lru_replacement regression: pass");
		else
			$display("true_lru_replacement regression: fail");
		$finish;
	end

endmodule
